// File: hdl/cfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 256;
  localparam int HDR_BYTES   = 32;
  localparam int CHUNK_BYTES = FRAME_BYTES - HDR_BYTES;
  localparam int FRAME_WORDS = (FRAME_BYTES + 7) / 8;
  localparam int HDR_WORDS   = HDR_BYTES / 8;
  localparam int CHUNK_WORDS = (CHUNK_BYTES + 7) / 8;
  localparam int WORD_W      = $clog2(FRAME_WORDS);
  localparam int CWORD_W     = $clog2(CHUNK_WORDS);
  localparam int FILL_W      = $clog2(CHUNK_BYTES + 1);
  localparam int CMP_W       = WORD_W + FILL_W;

  // input word layout
  localparam int IN_TDATA_W = 264;
  localparam int LEN_W      = 24;

  // chunk count by reciprocal multiply
  localparam int DIV_X_W   = LEN_W + 1;
  localparam int DIV_SHIFT = 32;
  localparam longint unsigned DIV_M = (64'd1 << DIV_SHIFT) / CHUNK_BYTES;
  localparam int DIV_M_W   = $clog2(DIV_M + 1);
  localparam int PROD_W    = DIV_X_W + DIV_M_W;
  localparam int Q_W       = PROD_W - DIV_SHIFT;

  // job queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // header constants
  localparam logic [31:0] MAGIC      = 32'h424c5350;
  localparam logic [7:0]  VERSION    = 8'd1;
  localparam logic [7:0]  SUB_META   = 8'd1;
  localparam logic [7:0]  SUB_DATA   = 8'd2;
  localparam logic [15:0] META_LEN   = 16'd24;
  localparam logic [31:0] FMT_SCOPE  = 32'd2;
  localparam logic [31:0] FMT_LOGIC  = 32'd1;

  // commands and register indexes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;
  localparam logic [0:0] REG_DSO_CODE = 1'd0;
  localparam logic [0:0] REG_MSO_CODE = 1'd1;

  typedef enum logic [1:0] {
    JOB_META,
    JOB_META_EMPTY,
    JOB_DATA
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [7:0]         instrument;
    logic [31:0]        capture_id;
    logic [15:0]        index;
    logic [15:0]        count;
    logic [FILL_W-1:0]  len;
    logic               last;
    logic               bank;
    logic [5:0][31:0]   meta;
  } job_t;

  typedef struct packed {
    logic               en;
    logic               bank;
    logic [CWORD_W-1:0] addr;
    logic [63:0]        data;
  } chunk_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

endpackage

`default_nettype wire

// File: hdl/cfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [cfp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic [0:0]                       s_axis_tuser,
  input  wire logic [7:0]                       dso_code,
  input  wire logic [7:0]                       mso_code,
  input  wire logic                             q_full,
  output logic                                  push,
  output cfp_pkg::job_t                         push_job,
  output cfp_pkg::chunk_wr_t                    wr,
  input  wire cfp_pkg::bank_rel_t               rel
);
  import cfp_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV_MUL,
    F_DIV_FIX,
    F_COLLECT
  } front_state_t;

  front_state_t      state;
  logic [1:0]        bank_busy;
  logic              wbank;
  logic [FILL_W-1:0] fill;
  logic [7:0]        instr;
  logic [31:0]       capid;
  logic [LEN_W-1:0]  bytes_left;
  logic [15:0]       chunk_number;
  logic [15:0]       chunk_total;
  logic [63:0]       acc;
  logic [DIV_X_W-1:0] div_x;
  logic [PROD_W-1:0]  div_prod;

  logic              in_cmd;
  logic [7:0]        in_instr;
  logic [31:0]       in_capid;
  logic [LEN_W-1:0]  in_len;
  logic [31:0]       in_fmt;
  logic [7:0]        in_byte;
  logic [31:0]       fmt_sel;
  logic              accept;
  logic              take_start;
  logic              take_byte;
  logic [2:0]        byte_pos;
  logic [63:0]       acc_new;
  logic [FILL_W-1:0] fill_inc;
  logic [LEN_W-1:0]  left_dec;
  logic              chunk_done;
  logic [Q_W-1:0]    q0;
  logic [DIV_X_W-1:0] rem;
  logic [Q_W-1:0]    q_fix;
  logic [1:0]        bank_busy_next;

  always_comb begin
    in_cmd   = s_axis_tuser[0];
    in_instr = s_axis_tdata[7:0];
    in_capid = s_axis_tdata[39:8];
    in_len   = s_axis_tdata[63:40];
    in_fmt   = s_axis_tdata[255:224];
    in_byte  = s_axis_tdata[263:256];

    s_axis_tready = (state == F_IDLE || state == F_COLLECT) && !q_full && !bank_busy[wbank];
    accept     = s_axis_tvalid && s_axis_tready;
    take_start = accept && (in_cmd == CMD_START);
    take_byte  = accept && (in_cmd == CMD_DATA) && (state == F_COLLECT);

    if (in_fmt != 32'd0) begin
      fmt_sel = in_fmt;
    end else if (in_instr == dso_code || in_instr == mso_code) begin
      fmt_sel = FMT_SCOPE;
    end else begin
      fmt_sel = FMT_LOGIC;
    end

    // first byte of a word clears the bytes above it
    byte_pos = fill[2:0];
    if (byte_pos == 3'd0) begin
      acc_new = {56'd0, in_byte};
    end else begin
      acc_new = acc | ({56'd0, in_byte} << {byte_pos, 3'b000});
    end
    fill_inc   = fill + 1'b1;
    left_dec   = bytes_left - 1'b1;
    chunk_done = (fill_inc == FILL_W'(CHUNK_BYTES)) || (left_dec == '0);

    // quotient estimate is exact or one short
    q0    = div_prod[PROD_W-1:DIV_SHIFT];
    rem   = div_x - DIV_X_W'(DIV_X_W'(q0) * DIV_X_W'(CHUNK_BYTES));
    q_fix = (rem >= DIV_X_W'(CHUNK_BYTES)) ? q0 + 1'b1 : q0;

    push_job = '0;
    push     = 1'b0;
    if (take_start) begin
      push                = 1'b1;
      push_job.kind       = (in_len == '0) ? JOB_META_EMPTY : JOB_META;
      push_job.instrument = in_instr;
      push_job.capture_id = in_capid;
      push_job.index      = 16'd0;
      push_job.count      = 16'd1;
      push_job.len        = '0;
      push_job.last       = 1'b1;
      push_job.bank       = 1'b0;
      push_job.meta[0]    = s_axis_tdata[95:64];
      push_job.meta[1]    = s_axis_tdata[127:96];
      push_job.meta[2]    = s_axis_tdata[159:128];
      push_job.meta[3]    = s_axis_tdata[191:160];
      push_job.meta[4]    = s_axis_tdata[223:192];
      push_job.meta[5]    = fmt_sel;
    end else if (take_byte && chunk_done) begin
      push                = 1'b1;
      push_job.kind       = JOB_DATA;
      push_job.instrument = instr;
      push_job.capture_id = capid;
      push_job.index      = chunk_number;
      push_job.count      = chunk_total;
      push_job.len        = fill_inc;
      push_job.last       = (left_dec == '0);
      push_job.bank       = wbank;
    end

    wr.en   = take_byte && (byte_pos == 3'd7 || chunk_done);
    wr.bank = wbank;
    wr.addr = fill[CWORD_W+2:3];
    wr.data = acc_new;

    bank_busy_next = bank_busy;
    if (rel.en) begin
      bank_busy_next[rel.bank] = 1'b0;
    end
    if (take_byte && chunk_done) begin
      bank_busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      bank_busy <= '0;
      wbank     <= 1'b0;
      fill      <= '0;
    end else begin
      bank_busy <= bank_busy_next;
      unique case (state)
        F_IDLE, F_COLLECT: begin
          if (take_start) begin
            instr        <= in_instr;
            capid        <= in_capid;
            bytes_left   <= in_len;
            chunk_number <= 16'd0;
            fill         <= '0;
            div_x        <= DIV_X_W'(in_len) + DIV_X_W'(CHUNK_BYTES - 1);
            state        <= (in_len == '0) ? F_IDLE : F_DIV_MUL;
          end else if (take_byte) begin
            acc        <= acc_new;
            bytes_left <= left_dec;
            if (chunk_done) begin
              fill         <= '0;
              chunk_number <= chunk_number + 16'd1;
              wbank        <= ~wbank;
              if (left_dec == '0) begin
                state <= F_IDLE;
              end
            end else begin
              fill <= fill_inc;
            end
          end
        end
        F_DIV_MUL: begin
          div_prod <= PROD_W'(div_x) * PROD_W'(DIV_M);
          state    <= F_DIV_FIX;
        end
        F_DIV_FIX: begin
          chunk_total <= q_fix[15:0];
          state       <= F_COLLECT;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/cfp_job_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_job_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cfp_pkg::job_t  push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output cfp_pkg::job_t       head
);
  import cfp_pkg::*;

  job_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push_ok;
  logic              pop_ok;

  always_comb begin
    full    = (count == QCNT_W'(QUEUE_DEPTH));
    empty   = (count == '0);
    head    = entry[rd_ptr];
    push_ok = push && !full;
    pop_ok  = pop && !empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        entry[wr_ptr] <= push_job;
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push_ok) - QCNT_W'(pop_ok);
    end
  end

endmodule

`default_nettype wire

// File: hdl/cfp_emitter.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_emitter (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  input  wire cfp_pkg::job_t         head,
  output logic                       pop,
  input  wire cfp_pkg::chunk_wr_t    wr,
  output cfp_pkg::bank_rel_t         rel,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [63:0]                m_axis_tdata,  // frame_word
  output logic [1:0]                 m_axis_tuser,  // frame_subtype, capture_end
  output logic                       m_axis_tlast
);
  import cfp_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_LOAD,
    B_SEND
  } back_state_t;

  back_state_t       state;
  job_t              job;
  logic [WORD_W-1:0] w;
  logic              second;
  logic [63:0]       mem [2][CHUNK_WORDS];
  logic [63:0]       mem_q;

  logic              is_data;
  logic [7:0]        hdr_sub;
  logic [15:0]       hdr_idx;
  logic [15:0]       hdr_cnt;
  logic [15:0]       hdr_len;
  logic [WORD_W-1:0] p;
  logic [CMP_W-1:0]  words_used;
  logic              in_pay;
  logic              frame_end;
  logic              cap_end;
  logic [63:0]       word;

  always_comb begin
    pop     = (state == B_IDLE) && !q_empty;
    // second frame of an empty capture is its data frame
    is_data = (job.kind == JOB_DATA) || second;
    hdr_sub = is_data ? SUB_DATA : SUB_META;
    hdr_idx = is_data ? job.index : 16'd0;
    hdr_cnt = is_data ? job.count : 16'd0;
    hdr_len = is_data ? 16'(job.len) : META_LEN;

    p          = w - WORD_W'(HDR_WORDS);
    words_used = (CMP_W'(job.len) + CMP_W'(7)) >> 3;
    in_pay     = is_data && (w >= WORD_W'(HDR_WORDS)) && (CMP_W'(p) < words_used);
    frame_end  = (w == WORD_W'(FRAME_WORDS - 1));
    cap_end    = frame_end && is_data && job.last;

    priority if (w == WORD_W'(0)) begin
      word = {8'd0, hdr_sub, job.instrument, VERSION, MAGIC};
    end else if (w == WORD_W'(1)) begin
      word = {hdr_cnt, hdr_idx, job.capture_id};
    end else if (w == WORD_W'(2)) begin
      word = {48'd0, hdr_len};
    end else if (is_data) begin
      word = in_pay ? mem_q : 64'd0;
    end else if (w == WORD_W'(HDR_WORDS)) begin
      word = {job.meta[1], job.meta[0]};
    end else if (w == WORD_W'(HDR_WORDS + 1)) begin
      word = {job.meta[3], job.meta[2]};
    end else if (w == WORD_W'(HDR_WORDS + 2)) begin
      word = {job.meta[5], job.meta[4]};
    end else begin
      word = 64'd0;
    end

    rel.en   = (state == B_SEND) && m_axis_tready && frame_end && (job.kind == JOB_DATA);
    rel.bank = job.bank;
  end

  // two chunk banks: the front fills one while the other is sent
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.bank][wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_FETCH && in_pay) begin
      mem_q <= mem[job.bank][p[CWORD_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      second        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            job    <= head;
            w      <= '0;
            second <= 1'b0;
            state  <= B_FETCH;
          end
        end
        B_FETCH: begin
          state <= B_LOAD;
        end
        B_LOAD: begin
          m_axis_tdata  <= word;
          m_axis_tuser  <= {cap_end, is_data};
          m_axis_tlast  <= frame_end;
          m_axis_tvalid <= 1'b1;
          state         <= B_SEND;
        end
        B_SEND: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (!frame_end) begin
              w     <= w + 1'b1;
              state <= B_FETCH;
            end else if (job.kind == JOB_META_EMPTY && !second) begin
              second <= 1'b1;
              w      <= '0;
              state  <= B_FETCH;
            end else begin
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/capture_frame_packetizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Capture frame packetizer. A start word (tuser 0) opens a capture and queues one
// 256-byte meta frame; data words (tuser 1) carry one byte each and are packed into
// 224-byte chunks, each sent as a 256-byte data frame, the last one flagged with
// capture_end; an empty capture gives the meta frame and one empty data frame.
// Frames leave as 32 little-endian 64-bit words with tlast on the last word.
// Data bytes are taken one per cycle while the chunk bank being filled is free
// and the job queue is not full; the two chunk banks let one chunk fill while
// the previous one is sent. After a start word with a nonzero length, input is
// held off while the chunk count comes from a reciprocal multiply (F_DIV_MUL,
// then F_DIV_FIX); after an empty one the input goes straight back to idle. The
// sender builds each output word by a chunk memory read, a word build and a
// hand-off, taking a job from the queue before the first word of its frames.
// Bytes arriving with no open capture are accepted and dropped.

module capture_frame_packetizer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // instrument, capture_id, total_length, rate_hz, samples_total, channels,
  // pin_or_channel, trigger_kind, format_code, data_byte
  input  wire logic [cfp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [0:0]                      s_axis_tuser,  // cmd
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [63:0]                          m_axis_tdata,  // frame_word
  output logic [1:0]                           m_axis_tuser,  // frame_subtype, capture_end
  output logic                                 m_axis_tlast,  // frame_end
  input  wire logic                            cfg_we,
  input  wire logic [0:0]                      cfg_index,
  input  wire logic [7:0]                      cfg_wdata
);
  import cfp_pkg::*;

  logic [7:0] dso_code;
  logic [7:0] mso_code;
  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       head;
  chunk_wr_t  wr;
  bank_rel_t  rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      dso_code <= 8'd1;
      mso_code <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DSO_CODE: dso_code <= cfg_wdata;
        REG_MSO_CODE: mso_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cfp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .dso_code      (dso_code),
    .mso_code      (mso_code),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job),
    .wr            (wr),
    .rel           (rel)
  );

  cfp_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  cfp_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head          (head),
    .pop           (pop),
    .wr            (wr),
    .rel           (rel),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
